@@ rtl/foc_pkg.sv @@
package foc_pkg;

  // Sine/cosine lookup: points per electrical turn (power of two)
  localparam int SINE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);

  // Shared multiply-accumulate widths
  localparam int A_W   = 20;
  localparam int B_W   = 20;
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = P_W + 2;

  // Fixed-point constants
  localparam logic signed [B_W-1:0] K_CURRENT     = B_W'(221278);
  localparam logic signed [B_W-1:0] K_INV_SQRT3   = B_W'(18919);
  localparam logic signed [B_W-1:0] K_2_INV_SQRT3 = B_W'(37838);
  localparam logic signed [B_W-1:0] K_HALF        = B_W'(16384);
  localparam logic signed [B_W-1:0] K_HALF_SQRT3  = B_W'(28378);
  localparam logic signed [B_W-1:0] K_DUTY_FULL   = B_W'(65535);
  localparam logic signed [B_W-1:0] K_ONE         = B_W'(1);
  localparam logic [15:0]           DUTY_MID      = 16'h8000;
  localparam logic [15:0]           DUTY_MAX      = 16'hFFFF;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_ANGLE_OFFSET = 3'd0,
    REG_POLE_COUNT   = 3'd1,
    REG_PROP_GAIN    = 3'd2,
    REG_INTEG_GAIN   = 3'd3,
    REG_BUS_VOLTAGE  = 3'd4,
    REG_USE_PI       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] angle_offset;
    logic [5:0]  pole_pair_count;
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [14:0] bus_voltage;
    logic        use_pi_output;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic clear;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Sequencer steps
  typedef enum logic [5:0] {
    ST_IDLE, ST_ELEC, ST_IA, ST_IB, ST_LIM, ST_IB_ST,
    ST_BETA0, ST_BETA1, ST_BETA_W, ST_BETA_ST,
    ST_ID0, ST_ID1, ST_IQ0, ST_IQ1, ST_IQ_W, ST_IQ_ST, ST_ERR,
    ST_PID0, ST_PID1, ST_PIQ0, ST_PIQ1, ST_VD, ST_TQ, ST_VQ,
    ST_VAL0, ST_VAL1, ST_VBE0, ST_VBE1, ST_VBE_W, ST_VBE_ST,
    ST_PB0, ST_PB1, ST_PC0, ST_PC1, ST_PC_W, ST_PC_ST,
    ST_DU0, ST_DU1, ST_DU_W, ST_DU_ST, ST_DU_DIV, ST_DONE
  } state_t;

  typedef logic signed [15:0] sine_rom_t [SINE_DEPTH];

  // sin(pi/2 * x/16384) in Q15, odd 7th order polynomial
  function automatic longint quarter_sine(longint x);
    longint z2;
    longint p;
    longint s;
    z2 = (x * x) >>> 14;
    p  = 5223 - ((307 * z2) >>> 14);
    p  = 42334 - ((p * z2) >>> 14);
    p  = 102944 - ((p * z2) >>> 14);
    s  = (p * x) >>> 15;
    return (s > 32767) ? 32767 : s;
  endfunction

  function automatic longint sine_turn(longint a);
    longint q;
    longint x;
    longint r;
    q = (a >>> 14) & 3;
    x = a & 16383;
    case (q)
      0:       r = quarter_sine(x);
      1:       r = quarter_sine(16384 - x);
      2:       r = -quarter_sine(x);
      default: r = -quarter_sine(16384 - x);
    endcase
    return r;
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t t;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      t[i] = 16'(sine_turn((longint'(i) << 16) / SINE_DEPTH));
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // Divide by 2^k, rounding half away from zero
  function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] x,
                                                        input int k);
    logic signed [ACC_W-1:0] h;
    logic signed [ACC_W-1:0] y;
    h = ACC_W'(1) <<< (k - 1);
    y = x[ACC_W-1] ? (x + h - ACC_W'(1)) : (x + h);
    return y >>> k;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
    logic signed [15:0] r;
    if (x > ACC_W'(32767)) r = 16'sh7FFF;
    else if (x < -ACC_W'(32768)) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

endpackage

@@ rtl/foc_current_loop_modulator.sv @@
// Field-oriented current loop and three-phase modulator.
// Input channel (in_valid / in_stall): one transfer per control period carries
// the three ADC codes, the angle load/value, speed step, iq target and vq command.
// Output channel (out_valid / out_stall): one transfer per input with the three
// duties, d/q currents, clamped d/q PI voltages and the electrical angle.
// Configuration goes through the APB port, one 32-bit word per register at
// byte address 4*i; change it only while the block is idle.
// All multiplies share one registered multiply-accumulate unit stepped by the
// sequencer (35 steps), then each of the three duties needs a shift-subtract
// divide by twice the bus voltage. in_stall stays high for the whole item;
// the next item is taken as soon as the sequencer is idle.
// A finished result sits in the output register; if the receiver stalls, it is
// held and the following item waits in its last step until it is taken.
// Reset (rst, synchronous) loads the register defaults, clears the angle and
// the PI history, and empties the output register.
module foc_current_loop_modulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        adc_phase_a,
  input  logic [11:0]        adc_phase_b,
  input  logic [11:0]        adc_reference,
  input  logic               angle_load,
  input  logic [15:0]        angle_value,
  input  logic signed [15:0] speed_step,
  input  logic signed [15:0] iq_target,
  input  logic signed [15:0] vq_command,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        duty_phase_a,
  output logic [15:0]        duty_phase_b,
  output logic [15:0]        duty_phase_c,
  output logic signed [15:0] d_current,
  output logic signed [15:0] q_current,
  output logic signed [15:0] d_pi_voltage,
  output logic signed [15:0] q_pi_voltage,
  output logic [15:0]        electrical_angle
);
  import foc_pkg::*;

  cfg_t      cfg;
  state_t    state, state_next;
  mac_ctrl_t mac_ctrl;
  div_stat_t div_stat;

  logic signed [A_W-1:0]   mac_a;
  logic signed [B_W-1:0]   mac_b;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] r10, r15, r16;

  // Latched inputs
  logic [11:0]        adc_a_q, adc_b_q, adc_ref_q;
  logic signed [15:0] iq_target_q, vq_command_q;

  // Working registers
  logic [15:0]        mech_angle, elec;
  logic signed [15:0] sin_q, cos_q;
  logic signed [15:0] ia, ib, ibeta, id, iq, ed, eq;
  logic [14:0]        lim;
  logic signed [25:0] td, tq;
  logic signed [15:0] d_error_prev, q_error_prev, d_volt_prev, q_volt_prev;
  logic signed [17:0] valpha, vbeta, vb, vc;
  logic [15:0]        duty_a, duty_b, duty_c;
  logic [1:0]         ph;
  logic               neg, ovf;

  // Derived operands
  logic [15:0]            mech_rel;
  logic signed [12:0]     diff_a, diff_b;
  logic signed [16:0]     neg_ia, ed_delta, eq_delta, neg_vq;
  logic signed [15:0]     vd_sel, vq_sel;
  logic signed [18:0]     neg_valpha, neg_vbeta;
  logic signed [17:0]     v_ph;
  logic signed [A_W-1:0]  duty_base;
  logic signed [26:0]     vd_sum, vq_sum;
  logic signed [26:0]     lim_pos, lim_neg;
  logic [15:0]            div_den, div_quo, duty_val;
  logic [SINE_IDX_W-1:0]  sin_idx, cos_idx;
  logic                   in_xfer, out_xfer, finish, div_start;

  foc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  foc_mac u_mac (
    .clk, .rst, .a(mac_a), .b(mac_b), .ctrl(mac_ctrl), .acc
  );

  foc_div u_div (
    .clk, .rst, .start(div_start), .num(acc[31:0]), .den(div_den),
    .quo(div_quo), .stat(div_stat)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign finish   = (state == ST_DONE) && (!out_valid || !out_stall);

  assign r10 = rnd_shift(acc, 10);
  assign r15 = rnd_shift(acc, 15);
  assign r16 = rnd_shift(acc, 16);

  assign mech_rel   = mech_angle - cfg.angle_offset;
  assign diff_a     = $signed({1'b0, adc_a_q}) - $signed({1'b0, adc_ref_q});
  assign diff_b     = $signed({1'b0, adc_b_q}) - $signed({1'b0, adc_ref_q});
  assign neg_ia     = -17'(ia);
  assign ed_delta   = 17'(ed) - 17'(d_error_prev);
  assign eq_delta   = 17'(eq) - 17'(q_error_prev);
  assign vd_sel     = cfg.use_pi_output ? d_volt_prev : 16'sd0;
  assign vq_sel     = cfg.use_pi_output ? q_volt_prev : vq_command_q;
  assign neg_vq     = -17'(vq_sel);
  assign neg_valpha = -19'(valpha);
  assign neg_vbeta  = -19'(vbeta);
  assign div_den    = {cfg.bus_voltage, 1'b0};
  assign sin_idx    = elec[15 -: SINE_IDX_W];
  assign cos_idx    = sin_idx + SINE_IDX_W'(SINE_DEPTH / 4);

  always_comb begin
    case (ph)
      2'd0:    v_ph = valpha;
      2'd1:    v_ph = vb;
      default: v_ph = vc;
    endcase
  end

  assign duty_base = (A_W'(v_ph) <<< 1) + A_W'($signed({1'b0, cfg.bus_voltage}));

  // PI sum and clamp
  assign vd_sum  = 27'(d_volt_prev) + 27'(td);
  assign vq_sum  = 27'(q_volt_prev) + 27'(tq);
  assign lim_pos = 27'($signed({1'b0, lim}));
  assign lim_neg = -lim_pos;

  // Duty with saturation overrides
  always_comb begin
    if (cfg.bus_voltage == 15'd0) duty_val = DUTY_MID;
    else if (neg) duty_val = 16'd0;
    else if (ovf) duty_val = DUTY_MAX;
    else duty_val = div_quo;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Sequencer: next step, multiply-accumulate issue and divider start
  always_comb begin
    state_next = state;
    mac_a      = '0;
    mac_b      = '0;
    mac_ctrl   = '0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_ELEC;
      ST_ELEC: begin
        mac_a = A_W'($signed({1'b0, mech_rel}));
        mac_b = B_W'($signed({1'b0, cfg.pole_pair_count}));
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_IA;
      end
      ST_IA: begin
        mac_a = A_W'(diff_a); mac_b = K_CURRENT;
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_IB;
      end
      ST_IB: begin
        mac_a = A_W'(diff_b); mac_b = K_CURRENT;
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_LIM;
      end
      ST_LIM: begin
        mac_a = A_W'($signed({1'b0, cfg.bus_voltage})); mac_b = K_INV_SQRT3;
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_IB_ST;
      end
      ST_IB_ST: state_next = ST_BETA0;
      ST_BETA0: begin
        mac_a = A_W'(ia); mac_b = K_INV_SQRT3;
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_BETA1;
      end
      ST_BETA1: begin
        mac_a = A_W'(ib); mac_b = K_2_INV_SQRT3;
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        state_next = ST_BETA_W;
      end
      ST_BETA_W: state_next = ST_BETA_ST;
      ST_BETA_ST: state_next = ST_ID0;
      ST_ID0: begin
        mac_a = A_W'(ia); mac_b = B_W'(cos_q);
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_ID1;
      end
      ST_ID1: begin
        mac_a = A_W'(ibeta); mac_b = B_W'(sin_q);
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        state_next = ST_IQ0;
      end
      ST_IQ0: begin
        mac_a = A_W'(ibeta); mac_b = B_W'(cos_q);
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_IQ1;
      end
      ST_IQ1: begin
        mac_a = A_W'(neg_ia); mac_b = B_W'(sin_q);
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        state_next = ST_IQ_W;
      end
      ST_IQ_W: state_next = ST_IQ_ST;
      ST_IQ_ST: state_next = ST_ERR;
      ST_ERR: state_next = ST_PID0;
      ST_PID0: begin
        mac_a = A_W'(ed_delta); mac_b = B_W'($signed({1'b0, cfg.prop_gain}));
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_PID1;
      end
      ST_PID1: begin
        mac_a = A_W'(ed); mac_b = B_W'($signed({1'b0, cfg.integ_gain}));
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        state_next = ST_PIQ0;
      end
      ST_PIQ0: begin
        mac_a = A_W'(eq_delta); mac_b = B_W'($signed({1'b0, cfg.prop_gain}));
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_PIQ1;
      end
      ST_PIQ1: begin
        mac_a = A_W'(eq); mac_b = B_W'($signed({1'b0, cfg.integ_gain}));
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        state_next = ST_VD;
      end
      ST_VD: state_next = ST_TQ;
      ST_TQ: state_next = ST_VQ;
      ST_VQ: state_next = ST_VAL0;
      ST_VAL0: begin
        mac_a = A_W'(vd_sel); mac_b = B_W'(cos_q);
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_VAL1;
      end
      ST_VAL1: begin
        mac_a = A_W'(neg_vq); mac_b = B_W'(sin_q);
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        state_next = ST_VBE0;
      end
      ST_VBE0: begin
        mac_a = A_W'(vd_sel); mac_b = B_W'(sin_q);
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_VBE1;
      end
      ST_VBE1: begin
        mac_a = A_W'(vq_sel); mac_b = B_W'(cos_q);
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        state_next = ST_VBE_W;
      end
      ST_VBE_W: state_next = ST_VBE_ST;
      ST_VBE_ST: state_next = ST_PB0;
      ST_PB0: begin
        mac_a = A_W'(neg_valpha); mac_b = K_HALF;
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_PB1;
      end
      ST_PB1: begin
        mac_a = A_W'(vbeta); mac_b = K_HALF_SQRT3;
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        state_next = ST_PC0;
      end
      ST_PC0: begin
        mac_a = A_W'(neg_valpha); mac_b = K_HALF;
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_PC1;
      end
      ST_PC1: begin
        mac_a = A_W'(neg_vbeta); mac_b = K_HALF_SQRT3;
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        state_next = ST_PC_W;
      end
      ST_PC_W: state_next = ST_PC_ST;
      ST_PC_ST: state_next = ST_DU0;
      ST_DU0: begin
        mac_a = duty_base; mac_b = K_DUTY_FULL;
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        state_next = ST_DU1;
      end
      ST_DU1: begin
        mac_a = A_W'($signed({1'b0, cfg.bus_voltage})); mac_b = K_ONE;
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        state_next = ST_DU_W;
      end
      ST_DU_W: state_next = ST_DU_ST;
      ST_DU_ST: begin
        div_start  = 1'b1;
        state_next = ST_DU_DIV;
      end
      ST_DU_DIV: begin
        if (div_stat.done) state_next = (ph == 2'd2) ? ST_DONE : ST_DU0;
      end
      ST_DONE: if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: angle, PI history, voltage limit, phase counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mech_angle   <= '0;
      d_error_prev <= '0;
      q_error_prev <= '0;
      d_volt_prev  <= '0;
      q_volt_prev  <= '0;
      lim          <= '0;
      ph           <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (in_xfer) begin
        mech_angle <= angle_load ? angle_value : mech_angle + speed_step;
        ph         <= '0;
      end
      if (state == ST_BETA0) lim <= r15[14:0];
      if (state == ST_VD) begin
        if (vd_sum > lim_pos) d_volt_prev <= lim_pos[15:0];
        else if (vd_sum < lim_neg) d_volt_prev <= lim_neg[15:0];
        else d_volt_prev <= vd_sum[15:0];
        d_error_prev <= ed;
      end
      if (state == ST_VQ) begin
        if (vq_sum > lim_pos) q_volt_prev <= lim_pos[15:0];
        else if (vq_sum < lim_neg) q_volt_prev <= lim_neg[15:0];
        else q_volt_prev <= vq_sum[15:0];
        q_error_prev <= eq;
      end
      if (state == ST_DU_DIV && div_stat.done) ph <= ph + 2'd1;
      if (finish) out_valid <= 1'b1;
      else if (out_xfer) out_valid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      adc_a_q      <= adc_phase_a;
      adc_b_q      <= adc_phase_b;
      adc_ref_q    <= adc_reference;
      iq_target_q  <= iq_target;
      vq_command_q <= vq_command;
    end
    case (state)
      ST_IB:     elec <= acc[15:0];
      ST_LIM: begin
        ia    <= r16[15:0];
        sin_q <= SINE_ROM[sin_idx];
        cos_q <= SINE_ROM[cos_idx];
      end
      ST_IB_ST:   ib <= r16[15:0];
      ST_BETA_ST: ibeta <= r15[15:0];
      ST_IQ1:     id <= sat16(r15);
      ST_IQ_ST:   iq <= sat16(r15);
      ST_ERR: begin
        ed <= sat16(-ACC_W'(id));
        eq <= sat16(ACC_W'(iq_target_q) - ACC_W'(iq));
      end
      ST_PIQ1:   td <= r10[25:0];
      ST_TQ:     tq <= r10[25:0];
      ST_VBE1:   valpha <= r15[17:0];
      ST_VBE_ST: vbeta <= r15[17:0];
      ST_PC1:    vb <= r15[17:0];
      ST_PC_ST:  vc <= r15[17:0];
      ST_DU_ST: begin
        neg <= acc[ACC_W-1];
        ovf <= acc >= $signed(ACC_W'({div_den, 16'h0}));
      end
      ST_DU_DIV: begin
        if (div_stat.done) begin
          case (ph)
            2'd0:    duty_a <= duty_val;
            2'd1:    duty_b <= duty_val;
            default: duty_c <= duty_val;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (finish) begin
      duty_phase_a     <= duty_a;
      duty_phase_b     <= duty_b;
      duty_phase_c     <= duty_c;
      d_current        <= id;
      q_current        <= iq;
      d_pi_voltage     <= d_volt_prev;
      q_pi_voltage     <= q_volt_prev;
      electrical_angle <= elec;
    end
  end

  // Checks
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> (d_volt_prev <= $signed({1'b0, lim}) &&
                          d_volt_prev >= -$signed({1'b0, lim})))
    else $error("d-axis PI output outside clamp");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DU_DIV)
    else $error("divider result outside duty step");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    finish |=> (out_valid && state == ST_IDLE))
    else $error("finished item not presented");

endmodule

@@ rtl/foc_regs.sv @@
module foc_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output foc_pkg::cfg_t     cfg
);
  import foc_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_offset    <= 16'd16400;
      cfg.pole_pair_count <= 6'd7;
      cfg.prop_gain       <= 16'd11060;
      cfg.integ_gain      <= 16'd1480;
      cfg.bus_voltage     <= 15'd12288;
      cfg.use_pi_output   <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_ANGLE_OFFSET: cfg.angle_offset    <= pwdata[15:0];
        REG_POLE_COUNT:   cfg.pole_pair_count <= pwdata[5:0];
        REG_PROP_GAIN:    cfg.prop_gain       <= pwdata[15:0];
        REG_INTEG_GAIN:   cfg.integ_gain      <= pwdata[15:0];
        REG_BUS_VOLTAGE:  cfg.bus_voltage     <= pwdata[14:0];
        REG_USE_PI:       cfg.use_pi_output   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_ANGLE_OFFSET: prdata = {16'd0, cfg.angle_offset};
      REG_POLE_COUNT:   prdata = {26'd0, cfg.pole_pair_count};
      REG_PROP_GAIN:    prdata = {16'd0, cfg.prop_gain};
      REG_INTEG_GAIN:   prdata = {16'd0, cfg.integ_gain};
      REG_BUS_VOLTAGE:  prdata = {17'd0, cfg.bus_voltage};
      REG_USE_PI:       prdata = {31'd0, cfg.use_pi_output};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/foc_mac.sv @@
module foc_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [foc_pkg::A_W-1:0]      a,
  input  logic signed [foc_pkg::B_W-1:0]      b,
  input  foc_pkg::mac_ctrl_t                  ctrl,
  output logic signed [foc_pkg::ACC_W-1:0]    acc
);
  import foc_pkg::*;

  logic signed [P_W-1:0] prod;
  mac_ctrl_t             ctrl_q;

  // Product stage
  always_ff @(posedge clk) begin
    prod <= a * b;
    if (rst) ctrl_q <= '0;
    else ctrl_q <= ctrl;
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl_q.en) begin
      acc <= ctrl_q.clear ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

endmodule

@@ rtl/foc_div.sv @@
module foc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        num,
  input  logic [15:0]        den,
  output logic [15:0]        quo,
  output foc_pkg::div_stat_t stat
);
  import foc_pkg::*;

  // Restoring divider, one quotient bit per cycle; needs num < den * 2^16
  logic [15:0] rem;
  logic [15:0] lo;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem, lo[15]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= 5'd16;
      end else if (stat.busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[31:16];
      lo  <= num[15:0];
      dvs <= den;
    end else if (stat.busy) begin
      rem <= fits ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      lo  <= {lo[14:0], 1'b0};
      quo <= {quo[14:0], fits};
    end
  end

endmodule
